// ----- hdl/s2i_pkg.sv -----
// Package for the streaming string-to-int64 parser: widths, character codes,
// register indexes, the digit result struct and small character helpers.
// Depends on nothing; every other file of the block imports it.
package s2i_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CHAR_W          = 16;
  localparam int BASE_W          = 6;
  localparam int VALUE_W         = 64;
  localparam int CONSUMED_W      = 16;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_FIELDS_W    = VALUE_W + CONSUMED_W + 2;
  localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W       = 1;

  localparam logic [BASE_W-1:0] MAX_BASE     = 6'd36;
  localparam logic [BASE_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic              SIGNED_RESET = 1'b1;
  localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE     = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;

  localparam logic [VALUE_W-1:0] SIGNED_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SIGNED_NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] UNSIGNED_LIMIT   = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [CHAR_W-1:0] CH_TERM  = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 16'h007A;
  localparam logic [CHAR_W-1:0] CASE_GAP = 16'h0020;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 1'b1;

  // Outcome of one digit step, handed from the digit unit to the control.
  typedef struct packed {
    logic               hit;       // character is a digit of the base
    logic               overflow;  // new value would pass the limit
    logic [VALUE_W-1:0] acc;       // accumulator after the digit
  } digit_res_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // ASCII upper case to lower case only.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? c + CASE_GAP : c;
  endfunction

endpackage

// ----- hdl/s2i_digit.sv -----
// Digit unit of the string-to-int64 parser: decodes one character under a base,
// multiplies the accumulator by the base, adds the digit and checks the limit.
// Depends on s2i_pkg.
module s2i_digit
  import s2i_pkg::*;
(
  input  logic [CHAR_W-1:0]  ch,
  input  logic [BASE_W-1:0]  base,
  input  logic [VALUE_W-1:0] acc,
  input  logic               minus_seen,
  input  logic               signed_mode,
  output digit_res_t         res
);

  localparam int PROD_W = VALUE_W + BASE_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [CHAR_W-1:0]  lc;
  logic [CHAR_W-1:0]  num_off;
  logic [CHAR_W-1:0]  alpha_off;
  logic               is_num;
  logic               is_alpha;
  logic [BASE_W-1:0]  digit;
  logic [VALUE_W-1:0] limit;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum;

  always_comb begin
    lc        = fold_case(ch);
    num_off   = lc - CH_ZERO;
    alpha_off = lc - CH_LC_A;
    is_num    = (lc >= CH_ZERO) && (lc <= CH_NINE);
    is_alpha  = (lc >= CH_LC_A) && (lc <= CH_LC_Z);
    digit     = is_num ? num_off[BASE_W-1:0] : alpha_off[BASE_W-1:0] + BASE_DEC;

    // The magnitude may reach one more than the positive signed limit when a
    // minus sign was seen.
    if (!signed_mode) begin
      limit = UNSIGNED_LIMIT;
    end else if (minus_seen) begin
      limit = SIGNED_NEG_LIMIT;
    end else begin
      limit = SIGNED_POS_LIMIT;
    end

    // acc > (limit - digit) / base is the same test as acc * base + digit > limit.
    prod = PROD_W'(acc) * PROD_W'(base);
    sum  = SUM_W'(prod) + SUM_W'(digit);

    res.hit      = (is_num || is_alpha) && (digit < base) && (base > BASE_ONE);
    res.overflow = sum > SUM_W'(limit);
    res.acc      = res.overflow ? limit : sum[VALUE_W-1:0];
  end

endmodule

// ----- hdl/string_to_int64_parser_core.sv -----
// Top level of the streaming string-to-int64 parser: input register, parse
// control with its state, configuration registers and the result register.
// Depends on s2i_pkg and s2i_digit.
//
//  channel   | direction | payload (lowest bit first)                         | handshake
//  ----------+-----------+----------------------------------------------------+----------------
//  s_*       | in        | char_code[15:0]                                    | tvalid/tready
//  m_*       | out       | value[63:0], consumed_count[15:0], range_error,    | tvalid/tready
//            |           | bad_base, six zero pad bits                        |
//  cfg_*     | in        | cfg_index selects radix (0) or signed_mode (1)     | write enable
//
// Every character request is held in the input register and is then folded
// into the parse state by the digit unit (a 64 by 6 bit multiply, an add
// and a limit compare), so one character per cycle is sustained unless a
// terminator waits. A terminator passes from the input register into the
// result register. Only a terminator that finds the result register still
// held by an unaccepted result waits, and the input register then holds it
// and stops taking requests. Reset is synchronous and clears the control
// state, sets radix to 10 and signed_mode to 1; there is no clearing pass.
module string_to_int64_parser_core
  import s2i_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] char_code

  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [63:0] value, [79:64] consumed_count,
                                            // [80] range_error, [81] bad_base

  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BASE_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    PH_START,
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE,
    PH_BAD
  } phase_t;

  // Configuration registers, sampled on the first character of each string.
  logic [BASE_W-1:0] radix;
  logic              signed_mode;

  // Input register.
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;

  // Parse state.
  phase_t                 phase, phase_next;
  logic [VALUE_W-1:0]     acc, acc_next;
  logic                   minus_seen, minus_seen_next;
  logic [BASE_W-1:0]      active_base, active_base_next;
  logic [COUNT_WIDTH-1:0] char_count, char_count_next;
  logic                   overflowed, overflowed_next;
  logic                   signed_l, signed_l_next;

  // Result register.
  logic                   res_valid, res_valid_next;
  logic [VALUE_W-1:0]     res_value, res_value_next;
  logic [CONSUMED_W-1:0]  res_count, res_count_next;
  logic                   res_range, res_range_next;
  logic                   res_bad, res_bad_next;

  logic                   in_term;
  logic                   advance;
  logic                   res_load;
  phase_t                 eff_phase;
  logic [BASE_W-1:0]      eff_base;
  logic                   eff_signed;
  logic [BASE_W-1:0]      dig_base;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH+CONSUMED_W-1:0] count_wide;
  logic                   after_sign;
  logic                   take_digit;
  digit_res_t             dig;

  assign in_term  = (in_char == CH_TERM);
  // A terminator may only move on when the result register is free or drains now.
  assign advance  = in_valid && (!in_term || !res_valid || m_tready);
  assign res_load = advance && in_term;
  assign s_tready = !in_valid || advance;

  assign m_tvalid = res_valid;
  assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_bad, res_range, res_count,
                     res_value};

  // The first character of a string latches the base and the mode; an invalid
  // base sends the whole string to the bad phase right away.
  always_comb begin
    if (phase == PH_START) begin
      eff_base   = radix;
      eff_signed = signed_mode;
      eff_phase  = ((radix == BASE_ONE) || (radix > MAX_BASE)) ? PH_BAD : PH_WS;
    end else begin
      eff_base   = active_base;
      eff_signed = signed_l;
      eff_phase  = phase;
    end
  end

  // Base used by a digit taken now: automatic detection resolves to octal after
  // a leading zero and to decimal otherwise.
  always_comb begin
    if (eff_phase == PH_ZERO) begin
      dig_base = (eff_base == BASE_AUTO) ? BASE_OCT : eff_base;
    end else if ((eff_phase == PH_WS) || (eff_phase == PH_SIGN)) begin
      dig_base = (eff_base == BASE_AUTO) ? BASE_DEC : eff_base;
    end else begin
      dig_base = eff_base;
    end
  end

  s2i_digit u_digit (
    .ch          (in_char),
    .base        (dig_base),
    .acc         (acc),
    .minus_seen  (minus_seen),
    .signed_mode (eff_signed),
    .res         (dig)
  );

  assign count_inc  = (char_count == {COUNT_WIDTH{1'b1}}) ? char_count
                                                          : char_count + COUNT_WIDTH'(1);
  assign count_wide = {{CONSUMED_W{1'b0}}, char_count};

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    minus_seen_next  = minus_seen;
    active_base_next = active_base;
    char_count_next  = char_count;
    overflowed_next  = overflowed;
    signed_l_next    = signed_l;
    res_value_next   = res_value;
    res_count_next   = res_count;
    res_range_next   = res_range;
    res_bad_next     = res_bad;
    res_valid_next   = res_valid && !m_tready;
    after_sign       = 1'b0;
    take_digit       = 1'b0;

    if (res_load) begin
      res_valid_next = 1'b1;
      if (eff_phase == PH_BAD) begin
        res_value_next = '0;
        res_count_next = '0;
        res_range_next = 1'b0;
        res_bad_next   = 1'b1;
      end else begin
        res_value_next = minus_seen ? VALUE_W'(0) - acc : acc;
        res_count_next = count_wide[CONSUMED_W-1:0];
        res_range_next = overflowed;
        res_bad_next   = 1'b0;
      end
      phase_next       = PH_START;
      acc_next         = '0;
      minus_seen_next  = 1'b0;
      active_base_next = BASE_AUTO;
      char_count_next  = '0;
      overflowed_next  = 1'b0;
      signed_l_next    = eff_signed;
    end else if (advance) begin
      phase_next       = eff_phase;
      active_base_next = eff_base;
      signed_l_next    = eff_signed;
      unique case (eff_phase)
        PH_WS: begin
          if (is_space(in_char)) begin
            char_count_next = count_inc;
          end else if (in_char == CH_MINUS) begin
            minus_seen_next = 1'b1;
            char_count_next = count_inc;
            phase_next      = PH_SIGN;
          end else if (in_char == CH_PLUS) begin
            char_count_next = count_inc;
            phase_next      = PH_SIGN;
          end else begin
            after_sign = 1'b1;
          end
        end
        PH_SIGN: begin
          after_sign = 1'b1;
        end
        PH_ZERO: begin
          if (fold_case(in_char) == CH_LC_X) begin
            active_base_next = BASE_HEX;
            char_count_next  = count_inc;
            phase_next       = PH_DIGITS;
          end else begin
            active_base_next = dig_base;
            phase_next       = PH_DIGITS;
            take_digit       = 1'b1;
          end
        end
        PH_DIGITS: begin
          take_digit = 1'b1;
        end
        default: begin
        end
      endcase

      // A leading zero in automatic or hex mode may open a 0x prefix.
      if (after_sign) begin
        if ((in_char == CH_ZERO) &&
            ((eff_base == BASE_AUTO) || (eff_base == BASE_HEX))) begin
          char_count_next = count_inc;
          phase_next      = PH_ZERO;
        end else begin
          active_base_next = dig_base;
          phase_next       = PH_DIGITS;
          take_digit       = 1'b1;
        end
      end

      // The first character that is not a digit ends the number.
      if (take_digit) begin
        if (dig.hit) begin
          char_count_next = count_inc;
          acc_next        = dig.acc;
          overflowed_next = overflowed || dig.overflow;
        end else begin
          phase_next = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      signed_mode <= SIGNED_RESET;
      in_valid    <= 1'b0;
      phase       <= PH_START;
      acc         <= '0;
      minus_seen  <= 1'b0;
      active_base <= BASE_AUTO;
      char_count  <= '0;
      overflowed  <= 1'b0;
      signed_l    <= SIGNED_RESET;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIX:  radix       <= cfg_data;
          REG_SIGNED: signed_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      phase       <= phase_next;
      acc         <= acc_next;
      minus_seen  <= minus_seen_next;
      active_base <= active_base_next;
      char_count  <= char_count_next;
      overflowed  <= overflowed_next;
      signed_l    <= signed_l_next;
      res_valid   <= res_valid_next;
    end
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata[CHAR_W-1:0];
    end
    res_value <= res_value_next;
    res_count <= res_count_next;
    res_range <= res_range_next;
    res_bad   <= res_bad_next;
  end

  // A terminator always leaves a clean state for the next string.
  assert property (@(posedge clk) disable iff (rst)
    res_load |=> (phase == PH_START) && (acc == '0) && (char_count == '0))
    else $error("parse state not cleared after a result");

  // With an invalid base nothing is counted or accumulated.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BAD) |-> (acc == '0) && (char_count == '0) && !overflowed)
    else $error("bad base string changed the parse state");

  // A positive signed value never passes the positive signed limit.
  assert property (@(posedge clk) disable iff (rst)
    (phase != PH_START) && signed_l && !minus_seen |-> !acc[VALUE_W-1])
    else $error("signed accumulator passed its limit");

  // A bad base result carries value zero and count zero.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_bad |-> (res_value == '0) && (res_count == '0) && !res_range)
    else $error("bad base result carries data");

  // A waiting result is never overwritten by the next terminator.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !m_tready |-> !res_load)
    else $error("result register overwritten while held");

endmodule
